// ----- src/sine_degrees_quarter_table_interp_assert.svh -----
// ---------------------------------------------------------------------------
// sine_degrees_quarter_table_interp_assert.svh
// assertion macros shared by the sine block, sampled on clk, off in rst
// ---------------------------------------------------------------------------
`ifndef SINE_DEGREES_QUARTER_TABLE_INTERP_ASSERT_SVH
`define SINE_DEGREES_QUARTER_TABLE_INTERP_ASSERT_SVH

// same-cycle implication
`define SDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/sdq_pkg.sv -----
// ---------------------------------------------------------------------------
// sdq_pkg
// shared constants, types and the quarter-wave table for the sine block
// ---------------------------------------------------------------------------
package sdq_pkg;

  localparam int ANG_W     = 25;   // reduced angle, 0 to 360.0 in unsigned 9.16
  localparam int ROM_DEPTH = 257;
  localparam int ROM_AW    = 9;
  localparam int ROM_DW    = 17;

  localparam logic [ANG_W-1:0] CIRCLE_FX  = 25'd23592960;
  localparam logic [ANG_W-1:0] HALF_FX    = 25'd11796480;
  localparam logic [ANG_W-1:0] QUARTER_FX = 25'd5898240;
  localparam logic [ANG_W-1:0] THREE_Q_FX = 25'd17694720;
  localparam logic [17:0]      PHASE_MUL  = 18'h2d82d;

  typedef logic [ANG_W-1:0]  ang_t;
  typedef logic [ROM_AW-1:0] rom_addr_t;
  typedef logic [ROM_DW-1:0] rom_data_t;
  // entry k sits at bits k*ROM_DW and up
  typedef logic [ROM_DEPTH*ROM_DW-1:0] qrom_t;

  // round(sin(k * 90 / 256 deg) * 65536), evaluated at elaboration
  function automatic qrom_t qrom_init();
    qrom_t tbl;
    real   x;
    tbl = '0;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      x = real'(k) * 3.14159265358979323846 / 512.0;
      tbl[k*ROM_DW +: ROM_DW] = ROM_DW'(int'($sin(x) * 65536.0));
    end
    return tbl;
  endfunction

endpackage

// ----- src/sdq_reduce.sv -----
// ---------------------------------------------------------------------------
// sdq_reduce
// iterative modulo-360 reduction of a signed 16.16 angle on one subtractor
// ---------------------------------------------------------------------------
module sdq_reduce
  import sdq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output ang_t               result
);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_ITER = 3'b010,
    R_FIN  = 3'b100
  } red_state_t;

  red_state_t  state;
  logic [31:0] x;
  logic        neg;
  logic [2:0]  k;
  logic        neg_in;
  logic [32:0] sub_a;
  logic [32:0] sub_b;
  logic [32:0] diff;

  // zero goes the negative way: -0 mod 360 leaves 0
  assign neg_in = angle[31] | (angle == 32'sd0);

  always_comb begin
    case (state)
      R_IDLE: begin
        sub_a = neg_in ? 33'd0 : {angle[31], angle};
        sub_b = neg_in ? {angle[31], angle} : 33'd1;
      end
      R_ITER: begin
        sub_a = {1'b0, x};
        sub_b = {1'b0, {7'd0, CIRCLE_FX} << k};
      end
      R_FIN: begin
        // negative: 360 - r; positive: r + 1 as r minus all ones
        sub_a = neg ? {8'd0, CIRCLE_FX} : {1'b0, x};
        sub_b = neg ? {1'b0, x} : '1;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign diff = sub_a - sub_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        R_IDLE: begin
          if (start) begin
            x     <= diff[31:0];
            neg   <= neg_in;
            k     <= 3'd7;
            state <= R_ITER;
          end
        end
        R_ITER: begin
          if (!diff[32]) begin
            x <= diff[31:0];
          end
          k <= k - 3'd1;
          if (k == 3'd0) begin
            state <= R_FIN;
          end
        end
        R_FIN: begin
          result <= (neg && x == 32'd0) ? '0 : diff[ANG_W-1:0];
          done   <= 1'b1;
          state  <= R_IDLE;
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/sdq_rom.sv -----
// ---------------------------------------------------------------------------
// sdq_rom
// quarter-wave sine table, one registered read a cycle
// ---------------------------------------------------------------------------
module sdq_rom
  import sdq_pkg::*;
(
  input  logic      clk,
  input  rom_addr_t addr,
  output rom_data_t data
);

  localparam qrom_t QROM = qrom_init();

  always_ff @(posedge clk) begin
    data <= QROM[ROM_DW*addr +: ROM_DW];
  end

endmodule

// ----- src/sine_degrees_quarter_table_interp.sv -----
// ---------------------------------------------------------------------------
// sine_degrees_quarter_table_interp
// sine of a 16.16 degree angle from a quarter-wave table with interpolation
// ---------------------------------------------------------------------------
// An angle is taken at a clock edge with start high and busy low. The sine
// appears on sine_value for one cycle with done high, and busy drops in that
// same cycle; no new angle is taken while busy. The modulo-360 reduction
// runs eight restoring steps on one subtractor plus load and correction;
// the later states run one shared multiplier (phase, then interpolation)
// around two reads of the single table port.
// done cannot be held off: the result must be taken in the cycle it shows.
// ---------------------------------------------------------------------------
`include "sine_degrees_quarter_table_interp_assert.svh"

module sine_degrees_quarter_table_interp
  import sdq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle_degrees,
  output logic               busy,
  output logic               done,
  output logic signed [17:0] sine_value
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_REDUCE = 7'b0000010,
    S_PHASE  = 7'b0000100,
    S_ADDR0  = 7'b0001000,
    S_ADDR1  = 7'b0010000,
    S_INTERP = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;

  logic        red_start;
  logic        red_done;
  ang_t        red_result;

  ang_t        ang;
  logic [42:0] prod;
  logic [24:0] mul_a;
  logic [17:0] mul_b;
  logic [42:0] mul_p;

  logic               special;
  logic signed [17:0] special_val;
  logic               negate;
  logic [7:0]         slot;
  logic [15:0]        frac;
  rom_data_t          e0;

  logic [25:0] phase;
  logic        mirror;
  rom_addr_t   rom_addr;
  rom_data_t   rom_data;
  rom_data_t   slope;
  logic [16:0] mag;
  logic signed [17:0] val;

  assign busy      = (state != S_IDLE);
  assign red_start = start && (state == S_IDLE);

  sdq_reduce u_reduce (
    .clk    (clk),
    .rst    (rst),
    .start  (red_start),
    .angle  (angle_degrees),
    .done   (red_done),
    .result (red_result)
  );

  sdq_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  // phase and quarter decode
  assign phase  = prod[41:16];
  assign mirror = phase[24];

  assign rom_addr = (state == S_ADDR0) ? {1'b0, phase[23:16] ^ {8{mirror}}}
                                       : {1'b0, slot} + rom_addr_t'(1);

  // table rises, so the slope is never negative
  assign slope = rom_data - e0;

  // the one multiplier: angle times phase constant, then fraction times slope
  always_comb begin
    if (state == S_INTERP) begin
      mul_a = {9'd0, frac};
      mul_b = {1'b0, slope};
    end else begin
      mul_a = ang;
      mul_b = PHASE_MUL;
    end
  end

  assign mul_p = 43'(mul_a) * 43'(mul_b);

  assign mag = e0 + prod[32:16];
  assign val = signed'({1'b0, mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (red_done) begin
            ang   <= red_result;
            state <= S_PHASE;
          end
        end
        S_PHASE: begin
          prod    <= mul_p;
          special <= (ang == '0) || (ang == HALF_FX) || (ang == QUARTER_FX) ||
                     (ang == THREE_Q_FX);
          if (ang == QUARTER_FX) begin
            special_val <= 18'sd65536;
          end else if (ang == THREE_Q_FX) begin
            special_val <= -18'sd65536;
          end else begin
            special_val <= '0;
          end
          state <= S_ADDR0;
        end
        S_ADDR0: begin
          slot   <= phase[23:16] ^ {8{mirror}};
          frac   <= phase[15:0] ^ {16{mirror}};
          negate <= phase[25];
          state  <= S_ADDR1;
        end
        S_ADDR1: begin
          e0    <= rom_data;
          state <= S_INTERP;
        end
        S_INTERP: begin
          prod  <= mul_p;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (special) begin
            sine_value <= special_val;
          end else begin
            sine_value <= negate ? -val : val;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SDQ_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted beat did not raise busy")
  `SDQ_ASSERT_IMPL(a_done_idle, done, !busy, "result strobe while still busy")
  `SDQ_ASSERT_IMPL(a_done_range, done, (sine_value <= 18'sd65536) && (sine_value >= -18'sd65536), "sine out of range")
  `SDQ_ASSERT_IMPL(a_red_when, red_done, state == S_REDUCE, "reduction finished outside its wait")
  `SDQ_ASSERT_IMPL(a_red_range, red_done, red_result <= CIRCLE_FX, "reduced angle above 360")

endmodule

// ----- bench/sine_degrees_quarter_table_interp_tb.sv -----
// ---------------------------------------------------------------------------
// sine_degrees_quarter_table_interp_tb
// self-checking bench for the degree sine block: a local quarter-wave table
// and predictor give the expected sine of every accepted angle, and each done
// beat is compared in order against it; directed angles cover the exact
// points, range reduction and quadrant edges, random angles do the rest
// ---------------------------------------------------------------------------
module sine_degrees_quarter_table_interp_tb;

  localparam longint CIRCLE_DEG  = 64'sd23592960;
  localparam longint HALF_DEG    = 64'sd11796480;
  localparam longint QUARTER_DEG = 64'sd5898240;
  localparam longint THREE_Q_DEG = 64'sd17694720;
  localparam longint TURN_MUL    = 64'sh2d82d;
  localparam int     TABLE_SIZE  = 257;
  localparam int     MAX_PRINTS  = 100;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [17:0] sine;
  } sine_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [31:0] angle_degrees = '0;
  logic               busy;
  logic               done;
  logic signed [17:0] sine_value;

  int         quarter_sine [TABLE_SIZE];
  sine_beat_t pending_sines[$];
  int         error_count = 0;
  bit         burst_mode = 1'b0;

  sine_degrees_quarter_table_interp u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .angle_degrees(angle_degrees),
    .busy         (busy),
    .done         (done),
    .sine_value   (sine_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // (a * b) >> 60 on 128-bit product
  function automatic longint unsigned mul_q60(input longint unsigned a, input longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // taylor series for sin at 2^-60 precision, rounded to 16 fraction bits
  task automatic build_quarter_sine();
    longint unsigned pi60;
    longint unsigned x, x2, term, acc, n, kk;
    pi60 = 64'h3243F6A8885A308D;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      kk = k;
      x = (pi60 >> 9) * kk + (((pi60 & 64'd511) * kk) >> 9);
      x2 = mul_q60(x, x);
      term = x;
      acc = x;
      n = 1;
      while (n < 24 && term != 0) begin
        term = mul_q60(term, x2) / ((2 * n) * (2 * n + 1));
        if (n[0]) begin
          acc = (term > acc) ? 64'd0 : acc - term;
        end else begin
          acc = acc + term;
        end
        n++;
      end
      quarter_sine[k] = int'((acc + (64'd1 << 43)) >> 44);
    end
  endtask

  function automatic logic signed [17:0] predict_sine(input logic signed [31:0] a);
    longint      ang, res, frac, e0, e1;
    logic [31:0] phase, ph;
    int          slot;
    ang = a;
    if (ang < 0) begin
      ang = ang % CIRCLE_DEG;
      if (ang < 0) ang = ang + CIRCLE_DEG;
    end else if (ang > CIRCLE_DEG) begin
      ang = ((ang - 1) % CIRCLE_DEG) + 1;
    end
    if (ang == 0 || ang == HALF_DEG) begin
      res = 0;
    end else if (ang == QUARTER_DEG) begin
      res = 64'sh10000;
    end else if (ang == THREE_Q_DEG) begin
      res = -64'sh10000;
    end else begin
      phase = 32'((ang * TURN_MUL) >>> 16);
      ph = phase;
      slot = int'(ph[23:16]);
      // odd quarters run the table backwards
      if (ph[24]) begin
        slot = slot ^ 255;
        ph = ~ph;
      end
      frac = ph[15:0];
      e0 = quarter_sine[slot];
      e1 = quarter_sine[slot + 1];
      res = ((frac * (e1 - e0)) >>> 16) + e0;
      if (phase[25]) res = -res;
    end
    return res[17:0];
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("ERROR %0t: %s", $realtime, msg);
  endtask

  // result checker
  always @(posedge clk) begin
    sine_beat_t want;
    if (!rst && done) begin
      if (pending_sines.size() == 0) begin
        report_mismatch($sformatf("unexpected sine_value %0d with nothing pending", sine_value));
      end else begin
        want = pending_sines.pop_front();
        if (sine_value !== want.sine) begin
          report_mismatch($sformatf("angle %h: sine_value got %0d expected %0d",
                                    want.angle, sine_value, want.sine));
        end
      end
    end
  end

  // one angle beat; start stays high into the next beat when there is no gap
  task automatic send_angle(input logic signed [31:0] a);
    int gap;
    bit after_free;
    sine_beat_t beat;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    after_free = burst_mode ? 1'b0 : 1'($urandom_range(0, 1));
    if (gap > 0 || after_free) begin
      start <= 1'b0;
      if (after_free) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    angle_degrees <= a;
    do @(posedge clk); while (busy);
    beat.angle = a;
    beat.sine = predict_sine(a);
    pending_sines.push_back(beat);
  endtask

  task automatic wait_all_sines();
    start <= 1'b0;
    do @(posedge clk); while (pending_sines.size() != 0);
  endtask

  function automatic logic signed [31:0] deg(input int d);
    return 32'(longint'(d) <<< 16);
  endfunction

  task automatic test_exact_angles();
    send_angle(deg(0));
    send_angle(deg(90));
    send_angle(deg(180));
    send_angle(deg(270));
    send_angle(deg(360));
    send_angle(deg(-90));
    send_angle(deg(-180));
    send_angle(deg(-360));
    send_angle(deg(450));
    send_angle(deg(720));
  endtask

  task automatic test_field_extremes();
    send_angle(32'sh7fffffff);
    send_angle(32'sh80000000);
    send_angle(-32'sd1);
    send_angle(32'sd1);
    send_angle(32'sh00010000);
    send_angle(32'shffff0000);
  endtask

  task automatic test_quadrant_edges();
    send_angle(deg(45));
    send_angle(deg(135));
    send_angle(deg(225));
    send_angle(deg(315));
    send_angle(deg(90) - 1);
    send_angle(deg(90) + 1);
    send_angle(deg(360) + 1);
    send_angle(deg(270) - 1);
  endtask

  function automatic logic signed [31:0] random_angle();
    longint v;
    int     k;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 23592960);
      2: begin
        // exact points and their neighbors, a few circles off
        k = $urandom_range(0, 20);
        v = longint'($urandom_range(0, 4)) * QUARTER_DEG + (longint'(k) - 10) * CIRCLE_DEG
            + longint'($urandom_range(0, 4)) - 2;
      end
      3: v = (longint'($urandom_range(0, 10000)) - 5000) <<< 16;
      4: begin
        if ($urandom_range(0, 1)) v = 64'sh7fffffff - longint'($urandom_range(0, 70000));
        else v = -64'sh80000000 + longint'($urandom_range(0, 70000));
      end
      default: v = -longint'($urandom_range(0, 2 * 23592960));
    endcase
    return 32'(v);
  endfunction

  task automatic test_random_angles(input int count);
    for (int i = 0; i < count; i++) begin
      // stretches of back-to-back beats
      if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_angle(random_angle());
      if (i % 400 == 399) wait_all_sines();
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++) send_angle(random_angle());
    wait_all_sines();
    send_angle(deg(30));
    send_angle(deg(-30));
  endtask

  initial begin
    build_quarter_sine();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_exact_angles();
    test_field_extremes();
    test_quadrant_edges();
    test_drain_pause();
    test_random_angles(1650);
    wait_all_sines();
    repeat (20) @(posedge clk);
    if (pending_sines.size() != 0) begin
      report_mismatch($sformatf("%0d sine results never arrived", pending_sines.size()));
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
